// ===== design/cfr_pkg.sv =====
// Shared types and constants for the card reader frame receiver.
// No dependencies; used by every module of the block.
`default_nettype none

package cfr_pkg;

   // Result codes, first failing check wins.
   typedef enum logic [1:0] {
      RESULT_OK       = 2'd0,
      RESULT_CHECKSUM = 2'd1,
      RESULT_STATUS   = 2'd2,
      RESULT_HEADER   = 2'd3
   } result_code_type;

   // Register indexes on the csr port.
   localparam logic CSR_EXPECTED_ADDRESS = 1'b0;
   localparam logic CSR_EXPECTED_COMMAND = 1'b1;

   localparam logic [7:0] EXPECTED_ADDRESS_RESET = 8'h01;
   localparam logic [7:0] EXPECTED_COMMAND_RESET = 8'hA1;
   localparam logic [7:0] XOR_GOOD               = 8'hFF;

   typedef struct packed {
      logic [7:0] expected_address;
      logic [7:0] expected_command;
   } cfg_type;

   // One completed frame, as handed from front to back.
   typedef struct packed {
      logic        xor_ok;
      logic [7:0]  status_byte;
      logic [7:0]  address_byte;
      logic [7:0]  command_byte;
      logic [31:0] card_id;
      logic [7:0]  frame_length;
   } frame_rec_type;

endpackage

`default_nettype wire

// ===== design/cfr_front.sv =====
// Front end: takes received words, tracks frame position and captured bytes.
// Pushes one frame record per completed frame. Uses cfr_pkg.
`default_nettype none

module cfr_front #(
   parameter int FRAME_CAPACITY = 64
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  wire  [7:0]             rx_byte,
   output logic                   push,
   output cfr_pkg::frame_rec_type rec
);

   localparam int CW = $clog2(FRAME_CAPACITY);

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    length_ff, length_in;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    address_ff, address_in;
   logic [7:0]    command_ff, command_in;
   logic [7:0]    status_ff, status_in;
   logic [31:0]   id_ff, id_in;

   logic          start;
   logic [CW:0]   next_wide;
   logic          wrap;
   logic          complete;

   always_comb begin
      start      = (count_ff == '0);
      // frame start: captured bytes read as zero
      length_in  = start ? 8'h00 : length_ff;
      xor_in     = (start ? 8'h00 : xor_ff) ^ rx_byte;
      address_in = start ? 8'h00 : address_ff;
      command_in = start ? 8'h00 : command_ff;
      status_in  = start ? 8'h00 : status_ff;
      id_in      = start ? 32'h0 : id_ff;

      unique case (count_ff)
         CW'(0):  address_in     = rx_byte;
         CW'(1):  length_in      = rx_byte;
         CW'(2):  command_in     = rx_byte;
         CW'(4):  status_in      = rx_byte;
         CW'(7):  id_in[31:24]   = rx_byte;
         CW'(8):  id_in[23:16]   = rx_byte;
         CW'(9):  id_in[15:8]    = rx_byte;
         CW'(10): id_in[7:0]     = rx_byte;
         default: ;
      endcase

      next_wide = {1'b0, count_ff} + (CW+1)'(1);
      wrap      = (next_wide >= (CW+1)'(FRAME_CAPACITY));
      complete  = !wrap && (next_wide >= (CW+1)'(2))
                  && (9'(next_wide) == {1'b0, length_in});

      if (wrap || complete) begin
         count_in = '0;
      end else begin
         count_in = next_wide[CW-1:0];
      end

      push             = accept && complete;
      rec.xor_ok       = (xor_in == cfr_pkg::XOR_GOOD);
      rec.status_byte  = status_in;
      rec.address_byte = address_in;
      rec.command_byte = command_in;
      rec.card_id      = id_in;
      rec.frame_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // payload regs: no reset, masked at frame start
   always_ff @(posedge clock) begin
      if (accept) begin
         length_ff  <= length_in;
         xor_ff     <= xor_in;
         address_ff <= address_in;
         command_ff <= command_in;
         status_ff  <= status_in;
         id_ff      <= id_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/cfr_fifo.sv =====
// Two-entry queue of frame records between front and back.
// Uses cfr_pkg for the record type.
`default_nettype none

module cfr_fifo (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push,
   input  wire cfr_pkg::frame_rec_type push_rec,
   output logic                        full,
   output logic                        nonempty,
   input  wire                         pop,
   output cfr_pkg::frame_rec_type      head_rec
);

   cfr_pkg::frame_rec_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == 2'd2);
      nonempty  = (count_ff != 2'd0);
      head_rec  = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> nonempty)
      else $error("pop from empty queue");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== design/cfr_back.sv =====
// Back end: checks a frame record's checksum, status and header and holds
// the result word in the output register. Uses cfr_pkg.
`default_nettype none

module cfr_back (
   input  wire                         clock,
   input  wire                         reset,
   input  wire cfr_pkg::cfg_type       cfg,
   input  wire                         q_nonempty,
   input  wire cfr_pkg::frame_rec_type q_rec,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [1:0]                  rsp_result_code,
   output logic [31:0]                 rsp_card_id,
   output logic [7:0]                  rsp_frame_length
);

   logic                     valid_ff, valid_in;
   cfr_pkg::result_code_type code_ff, code_in;
   logic [31:0]              id_ff;
   logic [7:0]               length_ff;

   always_comb begin
      q_pop    = q_nonempty && (!valid_ff || !rsp_stall);
      valid_in = q_pop || (valid_ff && rsp_stall);
      priority if (!q_rec.xor_ok) begin
         code_in = cfr_pkg::RESULT_CHECKSUM;
      end else if (q_rec.status_byte != 8'h00) begin
         code_in = cfr_pkg::RESULT_STATUS;
      end else if (q_rec.address_byte != cfg.expected_address
                   || q_rec.command_byte != cfg.expected_command) begin
         code_in = cfr_pkg::RESULT_HEADER;
      end else begin
         code_in = cfr_pkg::RESULT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         code_ff   <= code_in;
         id_ff     <= q_rec.card_id;
         length_ff <= q_rec.frame_length;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_code  = code_ff;
   assign rsp_card_id      = id_ff;
   assign rsp_frame_length = length_ff;

endmodule

`default_nettype wire

// ===== design/card_reader_frame_receiver.sv =====
// Card reader frame receiver, top level: config registers plus front,
// queue and back. Depends on cfr_pkg, cfr_front, cfr_fifo, cfr_back.
//
// Usage:
//  - req channel: one received byte per word (req_rx_byte). A word is taken
//    when req_valid is high and req_stall low. Byte 1 of a frame is its total
//    length; once that many bytes are in (at least two), one rsp word follows.
//  - rsp channel: result_code (0 ok, 1 checksum, 2 status, 3 header),
//    card_id (frame bytes 7..10, byte 7 in the top bits, zero if not sent)
//    and frame_length. Taken when rsp_valid is high and rsp_stall low.
//  - csr port: csr_write_enable with csr_index 0 writes expected_address,
//    index 1 writes expected_command. Write only while the block is idle.
//  - Throughput: one byte per cycle while req_stall is low.
//  - Frame path: the edge that takes the last byte of a frame writes the
//    queue; the output register loads from the queue head when empty or not stalled.
//  - Reset: frame position cleared, queue and output emptied, registers back
//    to address 0x01 and command 0xA1. Input taken from the next cycle on.
//  - Receiver stall: the output word holds; up to two more finished frames
//    wait in the queue; req_stall rises only when that queue is full.
//  - A count reaching FRAME_CAPACITY without a length match wraps to zero
//    and the partial frame is dropped.
`default_nettype none

module card_reader_frame_receiver #(
   parameter int FRAME_CAPACITY = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_result_code,
   output logic [31:0] rsp_card_id,
   output logic [7:0]  rsp_frame_length,
   input  wire         csr_write_enable,
   input  wire         csr_index,
   input  wire  [7:0]  csr_write_data
);

   cfr_pkg::cfg_type       cfg_ff;
   cfr_pkg::frame_rec_type front_rec;
   cfr_pkg::frame_rec_type head_rec;
   logic                   accept;
   logic                   push;
   logic                   q_full;
   logic                   q_nonempty;
   logic                   q_pop;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_address <= cfr_pkg::EXPECTED_ADDRESS_RESET;
         cfg_ff.expected_command <= cfr_pkg::EXPECTED_COMMAND_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            cfr_pkg::CSR_EXPECTED_ADDRESS: cfg_ff.expected_address <= csr_write_data;
            cfr_pkg::CSR_EXPECTED_COMMAND: cfg_ff.expected_command <= csr_write_data;
            default: ;
         endcase
      end
   end

   // stall only on a full queue; a completing byte always has room then
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   cfr_front #(
      .FRAME_CAPACITY (FRAME_CAPACITY)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .push    (push),
      .rec     (front_rec)
   );

   cfr_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (front_rec),
      .full     (q_full),
      .nonempty (q_nonempty),
      .pop      (q_pop),
      .head_rec (head_rec)
   );

   cfr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_nonempty       (q_nonempty),
      .q_rec            (head_rec),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_code  (rsp_result_code),
      .rsp_card_id      (rsp_card_id),
      .rsp_frame_length (rsp_frame_length)
   );

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("frame pushed into full queue");

   a_pop_feeds_output: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid)
      else $error("queue pop did not load output");

   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !q_pop)
      else $error("output overwritten while stalled");

endmodule

`default_nettype wire
